// ----- hdl/mnv_pkg.sv -----
// ----------------------------------------------------------------------------
// mnv_pkg
// Shared types, constants and the note frequency table for the MIDI
// note-to-voice register block.
// ----------------------------------------------------------------------------
package mnv_pkg;

	localparam int NOTE_COUNT = 96;
	localparam int ROM_SIZE   = 96;
	localparam int ROM_AW     = $clog2(ROM_SIZE);

	localparam logic [7:0] AD_RESET = 8'h11;
	localparam logic [7:0] SR_RESET = 8'hd6;

	localparam logic       CFG_ATTACK_DECAY    = 1'b0;
	localparam logic       CFG_SUSTAIN_RELEASE = 1'b1;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

	localparam logic [7:0]  WAVE_BASE = 8'h10;
	localparam logic [7:0]  GATE_MASK = 8'hfe;
	localparam logic [15:0] FREQ_BEYOND_ROM = 16'hffff;

	typedef struct packed {
		logic       done;
		logic [7:0] status;
		logic [7:0] note;
		logic [7:0] velocity;
	} frame_t;

	localparam logic [15:0] NOTE_ROM [ROM_SIZE] = '{
		16'h0117, 16'h0127, 16'h0139, 16'h014b, 16'h015f, 16'h0174,
		16'h018a, 16'h01a1, 16'h01ba, 16'h01d4, 16'h01f0, 16'h020e,
		16'h022d, 16'h024e, 16'h0271, 16'h0296, 16'h02be, 16'h02e8,
		16'h0314, 16'h0343, 16'h0374, 16'h03a9, 16'h03e1, 16'h041c,
		16'h045a, 16'h049c, 16'h04e2, 16'h052d, 16'h057c, 16'h05cf,
		16'h0628, 16'h0685, 16'h06e8, 16'h0752, 16'h07c1, 16'h0837,
		16'h08b4, 16'h0939, 16'h09c5, 16'h0a5a, 16'h0af7, 16'h0b9e,
		16'h0c4f, 16'h0d0a, 16'h0dd1, 16'h0ea3, 16'h0f82, 16'h106e,
		16'h1168, 16'h1271, 16'h138a, 16'h14b3, 16'h15ee, 16'h173c,
		16'h189e, 16'h1a15, 16'h1ba2, 16'h1d46, 16'h1f04, 16'h20dc,
		16'h22d0, 16'h24e2, 16'h2714, 16'h2967, 16'h2bdd, 16'h2e79,
		16'h313c, 16'h3429, 16'h3744, 16'h3a8d, 16'h3e08, 16'h41b8,
		16'h45a1, 16'h49c5, 16'h4e28, 16'h52cd, 16'h57ba, 16'h5cf1,
		16'h6278, 16'h6853, 16'h6e87, 16'h751a, 16'h7c10, 16'h8371,
		16'h8b42, 16'h9389, 16'h9c4f, 16'ha59b, 16'haf74, 16'hb9e2,
		16'hc4f0, 16'hd0a6, 16'hdd0e, 16'hea33, 16'hf820, 16'hffff
	};

	function automatic logic [15:0] note_freq(input logic [7:0] note);
		logic [15:0] f;
		if (note < 8'(ROM_SIZE)) begin
			f = NOTE_ROM[note[ROM_AW-1:0]];
		end else begin
			f = FREQ_BEYOND_ROM;
		end
		return f;
	endfunction

endpackage

// ----- hdl/midi_note_to_voice_registers.sv -----
// ----------------------------------------------------------------------------
// midi_note_to_voice_registers
// Takes one MIDI byte per transaction and takes one per clock cycle. The
// velocity byte of a frame is decoded in the same cycle it is accepted and
// the voice write lands in a single result register, so a note-on or
// note-off write appears in the cycle after its velocity byte. The input is
// stalled only while that result register is full and not being taken.
// Note-on (note below 96) writes frequency, both envelope bytes and control
// with the gate set; note-off zeroes frequency and envelope and writes control
// as the stored waveform with the gate cleared. Other frames complete without a write.
// ----------------------------------------------------------------------------
module midi_note_to_voice_registers import mnv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  midi_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] voice_freq,
	output logic [7:0]  envelope_ad,
	output logic [7:0]  envelope_sr,
	output logic [7:0]  voice_control,
	output logic        is_note_on
);

	logic [7:0] attack_decay_q;
	logic [7:0] sustain_release_q;
	logic [7:0] waveform_q;
	logic       out_valid_q;
	logic       take;
	frame_t     frame;
	logic [3:0] kind;
	logic       note_off;
	logic       note_on;
	logic [7:0] new_wave;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	mnv_frame_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.midi_byte (midi_byte),
		.frame     (frame)
	);

	assign kind     = frame.status[7:4];
	assign note_off = frame.done && ((kind == KIND_NOTE_OFF) ||
		(kind == KIND_NOTE_ON && frame.velocity == 8'h00));
	assign note_on  = frame.done && kind == KIND_NOTE_ON && frame.velocity != 8'h00 &&
		frame.note < 8'(NOTE_COUNT);
	assign new_wave = (WAVE_BASE << frame.status[1:0]) | 8'h01;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_decay_q    <= AD_RESET;
			sustain_release_q <= SR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATTACK_DECAY:    attack_decay_q    <= cfg_data;
				CFG_SUSTAIN_RELEASE: sustain_release_q <= cfg_data;
				default:             attack_decay_q    <= attack_decay_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (note_on) begin
				waveform_q <= new_wave;
			end
			if (note_on || note_off) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (note_on) begin
			voice_freq    <= note_freq(frame.note);
			envelope_ad   <= attack_decay_q;
			envelope_sr   <= sustain_release_q;
			voice_control <= new_wave;
			is_note_on    <= 1'b1;
		end else if (note_off) begin
			voice_freq    <= '0;
			envelope_ad   <= '0;
			envelope_sr   <= '0;
			voice_control <= waveform_q & GATE_MASK;
			is_note_on    <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while result register free");

	a_note_on_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_note_on) |-> (voice_control[0] && $onehot(voice_control[7:4])))
		else $error("note-on control byte malformed");

	a_note_off_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_note_on) |->
		(!voice_control[0] && voice_freq == 16'h0000 && envelope_ad == 8'h00 &&
		envelope_sr == 8'h00))
		else $error("note-off transaction carries note-on fields");

	a_wave_tracks_note_on: assert property (@(posedge clk) disable iff (!arst_n)
		note_on |=> (waveform_q == voice_control && out_valid))
		else $error("stored waveform differs from note-on control byte");

endmodule

// ----- hdl/mnv_frame_parser.sv -----
// ----------------------------------------------------------------------------
// mnv_frame_parser
// Collects status, note and velocity bytes into a three-byte frame and
// flags the transaction that completes it.
// ----------------------------------------------------------------------------
module mnv_frame_parser import mnv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] midi_byte,
	output frame_t     frame
);

	localparam logic [1:0] PH_STATUS   = 2'd0;
	localparam logic [1:0] PH_NOTE     = 2'd1;
	localparam logic [1:0] PH_VELOCITY = 2'd2;

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic [7:0] status_q;
	logic [7:0] note_q;

	always_comb begin
		unique case (phase_q)
			PH_NOTE:     phase_d = PH_VELOCITY;
			PH_VELOCITY: phase_d = PH_STATUS;
			default:     phase_d = midi_byte[7] ? PH_NOTE : PH_STATUS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_STATUS;
			status_q <= '0;
			note_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			if (phase_q == PH_NOTE) begin
				note_q <= midi_byte;
			end else if (phase_q != PH_VELOCITY && midi_byte[7]) begin
				status_q <= midi_byte;
			end
		end
	end

	assign frame.done     = take && (phase_q == PH_VELOCITY);
	assign frame.status   = status_q;
	assign frame.note     = note_q;
	assign frame.velocity = midi_byte;

endmodule

// ----- tb/tb_midi_note_to_voice_registers.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_note_to_voice_registers
// Streams MIDI bytes into the note-to-voice block and checks every voice
// write against an in-bench parser model: directed frames for the corner
// cases, envelope register extremes, then long random traffic with random
// gaps on both sides, a gap-free stretch and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_midi_note_to_voice_registers;
	import mnv_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 400;

	localparam logic [7:0] GATE_ON     = 8'h01;
	localparam logic [7:0] GATE_CLEAR  = 8'hfe;
	localparam logic [7:0] WAVE_LOWEST = 8'h10;
	localparam logic [15:0] FREQ_NONE  = 16'hffff;

	typedef enum logic [1:0] {
		AWAIT_STATUS,
		AWAIT_NOTE,
		AWAIT_VELOCITY
	} parse_phase_e;

	typedef struct packed {
		logic [15:0] freq;
		logic [7:0]  ad;
		logic [7:0]  sr;
		logic [7:0]  control;
		logic        note_on;
	} voice_write_t;

	localparam logic [15:0] FREQ_TABLE [96] = '{
		16'h0117, 16'h0127, 16'h0139, 16'h014b, 16'h015f, 16'h0174,
		16'h018a, 16'h01a1, 16'h01ba, 16'h01d4, 16'h01f0, 16'h020e,
		16'h022d, 16'h024e, 16'h0271, 16'h0296, 16'h02be, 16'h02e8,
		16'h0314, 16'h0343, 16'h0374, 16'h03a9, 16'h03e1, 16'h041c,
		16'h045a, 16'h049c, 16'h04e2, 16'h052d, 16'h057c, 16'h05cf,
		16'h0628, 16'h0685, 16'h06e8, 16'h0752, 16'h07c1, 16'h0837,
		16'h08b4, 16'h0939, 16'h09c5, 16'h0a5a, 16'h0af7, 16'h0b9e,
		16'h0c4f, 16'h0d0a, 16'h0dd1, 16'h0ea3, 16'h0f82, 16'h106e,
		16'h1168, 16'h1271, 16'h138a, 16'h14b3, 16'h15ee, 16'h173c,
		16'h189e, 16'h1a15, 16'h1ba2, 16'h1d46, 16'h1f04, 16'h20dc,
		16'h22d0, 16'h24e2, 16'h2714, 16'h2967, 16'h2bdd, 16'h2e79,
		16'h313c, 16'h3429, 16'h3744, 16'h3a8d, 16'h3e08, 16'h41b8,
		16'h45a1, 16'h49c5, 16'h4e28, 16'h52cd, 16'h57ba, 16'h5cf1,
		16'h6278, 16'h6853, 16'h6e87, 16'h751a, 16'h7c10, 16'h8371,
		16'h8b42, 16'h9389, 16'h9c4f, 16'ha59b, 16'haf74, 16'hb9e2,
		16'hc4f0, 16'hd0a6, 16'hdd0e, 16'hea33, 16'hf820, 16'hffff
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_ATTACK_DECAY;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  midi_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] voice_freq;
	logic [7:0]  envelope_ad;
	logic [7:0]  envelope_sr;
	logic [7:0]  voice_control;
	logic        is_note_on;

	// parser model state
	parse_phase_e phase = AWAIT_STATUS;
	logic [7:0]   held_status = 8'h00;
	logic [7:0]   held_note = 8'h00;
	logic [7:0]   waveform = 8'h00;
	logic [7:0]   model_ad = AD_RESET;
	logic [7:0]   model_sr = SR_RESET;

	voice_write_t pending_voice_writes[$];

	int  errors = 0;
	int  cycles = 0;
	int  bytes_sent = 0;
	int  note_on_writes = 0;
	int  note_off_writes = 0;
	int  silent_frames = 0;
	int  config_settings = 0;
	bit  tx_calm = 1'b0;
	bit  rx_calm = 1'b0;
	int  hold_token = 0;
	int  hold_seen = 0;
	int  hold_left = 0;

	midi_note_to_voice_registers uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.midi_byte     (midi_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.voice_freq    (voice_freq),
		.envelope_ad   (envelope_ad),
		.envelope_sr   (envelope_sr),
		.voice_control (voice_control),
		.is_note_on    (is_note_on)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] freq_of_note(input logic [7:0] note);
		logic [15:0] f;
		if (note < 8'd96) begin
			f = FREQ_TABLE[note[6:0]];
		end else begin
			f = FREQ_NONE;
		end
		return f;
	endfunction

	function automatic void track_midi_byte(input logic [7:0] b);
		logic [3:0]   kind;
		voice_write_t w;
		case (phase)
			AWAIT_NOTE: begin
				held_note = b;
				phase = AWAIT_VELOCITY;
			end
			AWAIT_VELOCITY: begin
				phase = AWAIT_STATUS;
				kind = held_status[7:4];
				if (kind == KIND_NOTE_OFF || (kind == KIND_NOTE_ON && b == 8'h00)) begin
					w = '{16'h0000, 8'h00, 8'h00, waveform & GATE_CLEAR, 1'b0};
					pending_voice_writes.push_back(w);
					note_off_writes++;
				end else if (kind == KIND_NOTE_ON && held_note < NOTE_COUNT) begin
					waveform = (WAVE_LOWEST << held_status[1:0]) | GATE_ON;
					w = '{freq_of_note(held_note), model_ad, model_sr, waveform, 1'b1};
					pending_voice_writes.push_back(w);
					note_on_writes++;
				end else begin
					silent_frames++;
				end
			end
			default: begin
				if (b[7]) begin
					held_status = b;
					phase = AWAIT_NOTE;
				end else begin
					phase = AWAIT_STATUS;
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: random stalls, calm stretches and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_OFF_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		voice_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_voice_writes.size() == 0) begin
				$display("%0t: unexpected voice write freq %h control %h note_on %b",
					$time, voice_freq, voice_control, is_note_on);
				errors++;
			end else begin
				want = pending_voice_writes.pop_front();
				check_field("voice_freq", want.freq, voice_freq);
				check_field("envelope_ad", 16'(want.ad), 16'(envelope_ad));
				check_field("envelope_sr", 16'(want.sr), 16'(envelope_sr));
				check_field("voice_control", 16'(want.control), 16'(voice_control));
				check_field("is_note_on", 16'(want.note_on), 16'(is_note_on));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!tx_calm) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		midi_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_midi_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] status, input logic [7:0] note,
			input logic [7:0] velocity);
		send_byte(status);
		send_byte(note);
		send_byte(velocity);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_voice_writes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_envelope(input logic [7:0] ad, input logic [7:0] sr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ATTACK_DECAY;
		cfg_data <= ad;
		@(posedge clk);
		model_ad = ad;
		cfg_index <= CFG_SUSTAIN_RELEASE;
		cfg_data <= sr;
		@(posedge clk);
		model_sr = sr;
		cfg_we <= 1'b0;
		config_settings++;
	endtask

	task automatic send_random_frame();
		int          r;
		logic [7:0]  status;
		logic [7:0]  note;
		logic [7:0]  velocity;
		r = $urandom_range(99);
		if (r < 5) begin
			// lone status: breaks the next frame
			send_byte(8'($urandom_range(128, 255)));
		end else if (r < 12) begin
			send_byte(8'($urandom_range(0, 127)));
		end else begin
			if (r < 57) begin
				status = {KIND_NOTE_ON, 4'($urandom_range(0, 15))};
			end else if (r < 82) begin
				status = {KIND_NOTE_OFF, 4'($urandom_range(0, 15))};
			end else begin
				status = {4'($urandom_range(10, 15)), 4'($urandom_range(0, 15))};
			end
			if ($urandom_range(99) < 80) begin
				note = 8'($urandom_range(0, NOTE_COUNT - 1));
			end else begin
				note = 8'($urandom_range(NOTE_COUNT, 255));
			end
			if ($urandom_range(99) < 15) begin
				velocity = 8'h00;
			end else begin
				velocity = 8'($urandom_range(0, 255));
			end
			send_frame(status, note, velocity);
		end
	endtask

	task automatic test_directed_frames();
		tx_calm = 1'b1;
		rx_calm <= 1'b1;
		send_byte(8'h00);
		send_byte(8'h7f);
		send_frame(8'h80, 8'h3c, 8'h40);
		send_frame(8'h90, 8'h00, 8'h7f);
		send_frame(8'h91, 8'd95, 8'h01);
		send_frame(8'h92, 8'd96, 8'h40);
		send_frame(8'h9f, 8'h10, 8'hff);
		send_frame(8'h9e, 8'h85, 8'h80);
		send_frame(8'h93, 8'h3c, 8'h00);
		send_frame(8'hb0, 8'h01, 8'h02);
		send_frame(8'hff, 8'hff, 8'hff);
		wait_idle();
	endtask

	task automatic test_envelope_extremes();
		write_envelope(8'h00, 8'h00);
		send_frame(8'h90, 8'h30, 8'h40);
		send_frame(8'h80, 8'h30, 8'h00);
		send_frame(8'h92, 8'h5f, 8'h01);
		wait_idle();
		write_envelope(8'hff, 8'hff);
		send_frame(8'h93, 8'h00, 8'h7f);
		send_frame(8'h9a, 8'h45, 8'h00);
		send_frame(8'h81, 8'h00, 8'hff);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int frames);
		tx_calm = 1'b0;
		rx_calm <= 1'b0;
		write_envelope(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		repeat (frames) send_random_frame();
		wait_idle();
	endtask

	task automatic test_no_idle_stretch();
		tx_calm = 1'b1;
		rx_calm <= 1'b1;
		write_envelope(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		repeat (60) send_random_frame();
		wait_idle();
	endtask

	task automatic test_output_hold_off();
		tx_calm = 1'b0;
		rx_calm <= 1'b0;
		hold_token <= hold_token + 1;
		repeat (40) send_random_frame();
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_envelope_extremes();
		repeat (3) test_random_traffic(120);
		test_no_idle_stretch();
		test_output_hold_off();

		wait_idle();
		$display("Sent %0d MIDI bytes: %0d note-on writes, %0d note-off writes, %0d silent frames",
			bytes_sent, note_on_writes, note_off_writes, silent_frames);
		$display("Envelope settings used: %0d, plus a %0d-cycle output hold-off",
			config_settings, HOLD_OFF_CYCLES);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mnv_pkg.sv
hdl/mnv_frame_parser.sv
hdl/midi_note_to_voice_registers.sv
tb/tb_midi_note_to_voice_registers.sv
